>>> rtl/pbud_pkg.sv
// Shared types and constants for the bootstrap draw unit.
package pbud_pkg;

  localparam int VAL_W   = 32;
  localparam int TOT_W   = 48;
  localparam int CNT_W   = 11;
  localparam int ROW_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Depth of the value and count stores; the unit index ports are sized for it.
  localparam int MAX_UNITS = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_POP_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SHARE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

endpackage

>>> rtl/pbud_ram.sv
// Generic single-port RAM with registered read.
module pbud_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/pbud_mul.sv
// Shared 32x32 multiplier with a registered product.
module pbud_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

>>> rtl/pips_bootstrap_unit_draw.sv
// Top level of the bootstrap draw unit: sequencer, stores and shared multiplier.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  req     | req_valid req_ready req_type unit_index   | in
//          | aux_value uniform                         |
//  resp    | resp_valid resp_ready resp_kind           | out
//          | chosen_unit new_count row_done            |
//          | all_rows_done                             |
//
// A draw walks up to sample_size units (clamped to 1..MAX_UNITS): each walked unit needs
// a RAM read, a pass through the single shared 32x32 multiplier and an accumulate step. The
// threshold first takes two partial products in that multiplier. When a row completes, the
// count store is cleared one entry per cycle; after reset the same sweep runs before any
// item is taken. The block takes one item at a time; req_ready is low until the result has
// been transferred, and a stalled result simply holds.
module pips_bootstrap_unit_draw (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [9:0]  unit_index,
  input  logic [31:0] aux_value,
  input  logic [31:0] uniform,
  output logic        resp_valid,
  input  logic        resp_ready,
  output logic        resp_kind,
  output logic [9:0]  chosen_unit,
  output logic [10:0] new_count,
  output logic        row_done,
  output logic        all_rows_done
);

  localparam int MAX_UNITS = pbud_pkg::MAX_UNITS;
  localparam int AW = $clog2(MAX_UNITS);
  localparam int NW = $clog2(MAX_UNITS + 1);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_UNITS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_THI   = 4'd2;
  localparam logic [3:0] S_TLO   = 4'd3;
  localparam logic [3:0] S_TSUM  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CWAIT = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;
  localparam logic [3:0] S_LOAD  = 4'd12;

  // Configuration registers.
  logic [47:0] pop_total, unit_share;
  logic [10:0] sample_size;
  logic [15:0] row_count;

  logic [3:0]  state;
  logic [47:0] den, thr;
  logic [63:0] sum;
  logic [NW-1:0] walk, n_units;
  logic [AW-1:0] chosen;
  logic [10:0] draw_counter;
  logic [15:0] row_counter;
  logic [AW-1:0] clr_addr;
  logic        clr_last;
  logic        row_end;

  // Latched request.
  logic [9:0]  rq_index;
  logic [31:0] rq_aux, rq_uni;

  // Stores.
  logic          aux_we, cnt_we;
  logic [AW-1:0] aux_addr, cnt_addr;
  logic [31:0]   aux_wdata, aux_rdata;
  logic [10:0]   cnt_wdata, cnt_rdata;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] thr_hi;

  pbud_ram #(.WIDTH(32), .DEPTH(MAX_UNITS)) u_aux (
    .clk(clk), .we(aux_we), .addr(aux_addr), .wdata(aux_wdata), .rdata(aux_rdata)
  );
  pbud_ram #(.WIDTH(11), .DEPTH(MAX_UNITS)) u_cnt (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );
  pbud_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && !resp_valid;

  always_comb begin
    if (sample_size == 11'd0) begin
      n_units = NW'(1);
    end else if ({{(32-11){1'b0}}, sample_size} > 32'(MAX_UNITS)) begin
      n_units = N_MAX;
    end else begin
      n_units = NW'(sample_size);
    end
  end

  // The sequencer picks the multiplier operands.
  always_comb begin
    mul_a = {24'd0, 8'd0};
    mul_b = rq_uni;
    unique case (state)
      S_THI: begin
        mul_a = {16'd0, den[47:32]};
      end
      S_TLO: begin
        mul_a = den[31:0];
      end
      S_MUL: begin
        mul_a = {21'd0, cnt_rdata};
        mul_b = aux_rdata;
      end
      default: ;
    endcase
  end

  assign clr_last = (clr_addr == AW'(MAX_UNITS - 1));
  assign row_end  = ({{(NW > 11 ? NW-11 : 0){1'b0}}, draw_counter} + NW'(1)) >= n_units;

  always_comb begin
    aux_we = 1'b0;
    aux_addr = walk[AW-1:0];
    aux_wdata = rq_aux;
    cnt_we = 1'b0;
    cnt_addr = walk[AW-1:0];
    cnt_wdata = 11'd0;
    unique case (state) inside
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_addr = clr_addr;
      end
      S_LOAD: begin
        aux_we = ({{(32-10){1'b0}}, rq_index} < 32'(MAX_UNITS));
        aux_addr = rq_index[AW-1:0];
      end
      S_CRD, S_CWAIT: begin
        aux_addr = chosen;
        cnt_addr = chosen;
      end
      S_UPD: begin
        aux_addr = chosen;
        cnt_addr = chosen;
        cnt_we = 1'b1;
        cnt_wdata = (cnt_rdata < pbud_pkg::COUNT_MAX) ? cnt_rdata + 11'd1 : cnt_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_total <= '0;
      unit_share <= '0;
      sample_size <= 11'd1;
      row_count <= 16'd1;
      state <= S_CLEAR;
      clr_addr <= '0;
      draw_counter <= '0;
      row_counter <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pbud_pkg::REG_POP_TOTAL:   pop_total <= cfg_data;
          pbud_pkg::REG_UNIT_SHARE:  unit_share <= cfg_data;
          pbud_pkg::REG_SAMPLE_SIZE: sample_size <= cfg_data[10:0];
          pbud_pkg::REG_ROW_COUNT:   row_count <= cfg_data[15:0];
        endcase
      end
      if (resp_valid && resp_ready) begin
        resp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            rq_index <= unit_index;
            rq_aux <= aux_value;
            rq_uni <= uniform;
            walk <= '0;
            chosen <= '0;
            sum <= '0;
            if (draw_counter == 11'd0) begin
              den <= pop_total;
            end
            state <= (req_type == pbud_pkg::REQ_LOAD) ? S_LOAD : S_THI;
          end
        end
        S_LOAD: begin
          resp_kind <= pbud_pkg::REQ_LOAD;
          chosen_unit <= '0;
          new_count <= '0;
          row_done <= 1'b0;
          all_rows_done <= 1'b0;
          resp_valid <= 1'b1;
          state <= S_RESP;
        end
        S_THI: state <= S_TLO;
        S_TLO: begin
          thr_hi <= mul_p;
          state <= S_TSUM;
        end
        S_TSUM: begin
          thr <= 48'(thr_hi) + 48'(mul_p[63:32]);
          state <= S_RD;
        end
        S_RD: begin
          // Loop test: stop when all units walked or the sum reached threshold.
          if (walk >= n_units || sum >= {16'd0, thr}) begin
            state <= S_CRD;
          end else begin
            chosen <= walk[AW-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if ({16'd0, unit_share} > mul_p) begin
            sum <= sum + ({16'd0, unit_share} - mul_p);
          end
          walk <= walk + NW'(1);
          state <= S_RD;
        end
        S_CRD: state <= S_CWAIT;
        S_CWAIT: state <= S_UPD;
        S_UPD: begin
          resp_kind <= pbud_pkg::REQ_DRAW;
          chosen_unit <= 10'(chosen);
          new_count <= cnt_wdata;
          den <= (den > {16'd0, aux_rdata}) ? den - {16'd0, aux_rdata} : '0;
          row_done <= row_end;
          all_rows_done <= 1'b0;
          resp_valid <= 1'b1;
          if (row_end) begin
            draw_counter <= '0;
            if (row_counter + 16'd1 >= ((row_count == 16'd0) ? 16'd1 : row_count)) begin
              all_rows_done <= 1'b1;
              row_counter <= '0;
            end else begin
              row_counter <= row_counter + 16'd1;
            end
            clr_addr <= '0;
            state <= S_CLEAR;
          end else begin
            draw_counter <= draw_counter + 11'd1;
            state <= S_RESP;
          end
        end
        S_RESP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // A pending result is held until it is taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && !resp_ready) |=> resp_valid) else $error("result lost");
  // No request is taken while the count store is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req_ready) else $error("request during clear");
  // Accumulator holds still while leaving S_RESP; it is cleared when a request is taken.
  a_sum_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> $stable(sum)) else $error("sum moved after walk");

endmodule
